// ===== design/ngh_pkg.sv =====
`default_nettype none
package ngh_pkg;

	// Field widths of the sample, coefficient and hold paths.
	localparam int SAMPLE_BITS = 24;
	localparam int COEFF_BITS  = 24;
	localparam int HOLD_BITS   = 20;

	// Configuration port.
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = (SAMPLE_BITS > COEFF_BITS) ?
		((SAMPLE_BITS > HOLD_BITS) ? SAMPLE_BITS : HOLD_BITS) :
		((COEFF_BITS > HOLD_BITS) ? COEFF_BITS : HOLD_BITS);

	localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_THR  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_CLOSE_THR = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_RANGE     = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK    = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE   = CFG_IDX_BITS'(4);
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD      = CFG_IDX_BITS'(5);

	localparam logic [SAMPLE_BITS-1:0] RST_OPEN_THR  = SAMPLE_BITS'(83886);
	localparam logic [SAMPLE_BITS-1:0] RST_CLOSE_THR = SAMPLE_BITS'(42043);
	localparam logic [SAMPLE_BITS-1:0] RST_RANGE     = SAMPLE_BITS'(839);
	localparam logic [COEFF_BITS-1:0]  RST_ATTACK    = COEFF_BITS'(16401054);
	localparam logic [COEFF_BITS-1:0]  RST_RELEASE   = COEFF_BITS'(16773412);
	localparam logic [HOLD_BITS-1:0]   RST_HOLD      = HOLD_BITS'(2205);

	// Unity in the sample format.
	localparam logic [SAMPLE_BITS-1:0] ONE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Shared multiplier: signed operands with room for a sign and a carry bit.
	localparam int MUL_BITS  = ((SAMPLE_BITS > COEFF_BITS) ? SAMPLE_BITS : COEFF_BITS) + 2;
	localparam int PROD_BITS = 2 * MUL_BITS;

	// Rounding constants for the coefficient and the sample shifts.
	localparam logic signed [PROD_BITS-1:0] RND_C = PROD_BITS'(1) << (COEFF_BITS - 1);
	localparam logic signed [PROD_BITS-1:0] RND_S = PROD_BITS'(1) << (SAMPLE_BITS - 2);

	// Most negative hold count; the countdown saturates there.
	localparam logic signed [HOLD_BITS:0] HOLD_MIN = {1'b1, {HOLD_BITS{1'b0}}};

	typedef logic [SAMPLE_BITS-1:0] smp_t;
	typedef logic [COEFF_BITS-1:0]  coef_t;

	// Commands from the controller, one step of the item sequence each.
	typedef struct packed {
		logic load_smp;
		logic mul_env;
		logic upd_gate;
		logic mul_gain;
		logic upd_gain;
		logic mul_out;
		logic load_out;
	} cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== design/noise_gate_hysteresis_hold_top.sv =====
`default_nettype none
// Audio noise gate with hysteresis and hold. Each input transaction carries one
// signed Q1.23 sample and produces exactly one output transaction with the gated
// sample and the gate state after that sample. An envelope follower smooths the
// sample magnitude with the attack coefficient on a rising level and the release
// coefficient otherwise. A closed gate opens once the envelope reaches the open
// threshold; an open gate that sees the envelope below the close threshold counts
// its hold time down and closes when the count runs out. The gain glides toward
// unity while open and toward the range gain while closed, and is clamped between
// the two. A sample is taken in the idle state and then passes six steps of the
// controller, three of which use the single shared multiplier (envelope blend,
// gain step, output product), each followed by a step that consumes its
// registered product; no new sample is taken before that sequence ends. A
// transaction is finished into an output register, so the next sample is taken
// while a result waits on a stalled output; the sequence only pauses on its last
// step if the previous result is still held there. Configuration registers are
// written through cfg_we, cfg_index and cfg_data with no wait state and should
// only be written while no transaction is in flight. Writes to an index beyond
// the six registers are ignored.
module noise_gate_hysteresis_hold_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [ngh_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [ngh_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [ngh_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [ngh_pkg::SAMPLE_BITS-1:0]      sample_out,
	output logic                                        gate_is_open
);
	import ngh_pkg::*;

	// Command and status between the sequencer and the arithmetic.
	cmd_t  cmd;
	stat_t stat;

	// The controller steps each transaction through its phases.
	ngh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the gate state, the shared
	// multiplier and the output register.
	ngh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_in    (sample_in),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.sample_out   (sample_out),
		.gate_is_open (gate_is_open)
	);

endmodule
`default_nettype wire

// ===== design/ngh_ctrl.sv =====
`default_nettype none
module ngh_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire ngh_pkg::stat_t stat,
	output ngh_pkg::cmd_t      cmd
);
	import ngh_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_ENV_MUL  = 3'd1;
	localparam logic [2:0] ST_GATE     = 3'd2;
	localparam logic [2:0] ST_GAIN_MUL = 3'd3;
	localparam logic [2:0] ST_GAIN_UPD = 3'd4;
	localparam logic [2:0] ST_OUT_MUL  = 3'd5;
	localparam logic [2:0] ST_OUT_RND  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_smp = 1'b1;
					state_d      = ST_ENV_MUL;
				end
			end
			ST_ENV_MUL: begin
				cmd.mul_env = 1'b1;
				state_d     = ST_GATE;
			end
			ST_GATE: begin
				cmd.upd_gate = 1'b1;
				state_d      = ST_GAIN_MUL;
			end
			ST_GAIN_MUL: begin
				cmd.mul_gain = 1'b1;
				state_d      = ST_GAIN_UPD;
			end
			ST_GAIN_UPD: begin
				cmd.upd_gain = 1'b1;
				state_d      = ST_OUT_MUL;
			end
			ST_OUT_MUL: begin
				cmd.mul_out = 1'b1;
				state_d     = ST_OUT_RND;
			end
			ST_OUT_RND: begin
				// Wait here until the output register can take the result.
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_ENV_MUL))
		else $error("accepted transaction did not start the envelope step");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded while output register was occupied");

endmodule
`default_nettype wire

// ===== design/ngh_dp.sv =====
`default_nettype none
module ngh_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [ngh_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [ngh_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  wire logic signed [ngh_pkg::SAMPLE_BITS-1:0] sample_in,
	input  wire ngh_pkg::cmd_t                         cmd,
	output ngh_pkg::stat_t                             stat,
	input  wire logic                                  out_stall,
	output logic                                       out_valid,
	output logic signed [ngh_pkg::SAMPLE_BITS-1:0]     sample_out,
	output logic                                       gate_is_open
);
	import ngh_pkg::*;

	// Configuration registers.
	smp_t                 open_thr_q;
	smp_t                 close_thr_q;
	smp_t                 range_q;
	coef_t                attack_q;
	coef_t                release_q;
	logic [HOLD_BITS-1:0] hold_smp_q;

	// Per-item operands and the multiplier result.
	smp_t                        mag_q;
	logic                        neg_q;
	logic                        up_q;
	logic signed [PROD_BITS-1:0] prod_q;

	// Gate state.
	smp_t                        env_q;
	smp_t                        gain_q;
	logic                        gate_q;
	logic signed [HOLD_BITS:0]   hold_q;

	// Output register.
	logic                        out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                        gate_out_q;

	// Combinational signals.
	smp_t                        raw;
	smp_t                        mag_d;
	coef_t                       env_coef;
	coef_t                       gain_coef;
	logic [COEFF_BITS:0]         k;
	smp_t                        floor_gain;
	smp_t                        target;
	logic                        up_d;
	smp_t                        diff;
	logic signed [MUL_BITS-1:0]  mul_a;
	logic signed [MUL_BITS-1:0]  mul_b;
	logic signed [PROD_BITS-1:0] mul_p;
	logic signed [PROD_BITS-1:0] env_sum;
	logic [SAMPLE_BITS:0]        env_wide;
	smp_t                        env_d;
	logic signed [HOLD_BITS:0]   hold_dec;
	logic signed [PROD_BITS-1:0] step_sum;
	smp_t                        step;
	logic [SAMPLE_BITS:0]        gain_wide;
	smp_t                        gain_d;
	logic signed [PROD_BITS-1:0] out_sum;
	smp_t                        out_mag;

	assign raw   = smp_t'(sample_in);
	assign mag_d = raw[SAMPLE_BITS-1] ? (smp_t'(0) - raw) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_thr_q  <= RST_OPEN_THR;
			close_thr_q <= RST_CLOSE_THR;
			range_q     <= RST_RANGE;
			attack_q    <= RST_ATTACK;
			release_q   <= RST_RELEASE;
			hold_smp_q  <= RST_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OPEN_THR:  open_thr_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_CLOSE_THR: close_thr_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_RANGE:     range_q     <= cfg_data[SAMPLE_BITS-1:0];
				REG_ATTACK:    attack_q    <= cfg_data[COEFF_BITS-1:0];
				REG_RELEASE:   release_q   <= cfg_data[COEFF_BITS-1:0];
				REG_HOLD:      hold_smp_q  <= cfg_data[HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Gain target and smoothing direction follow the gate state of this item.
	assign floor_gain = (range_q > ONE) ? ONE : range_q;
	assign target     = gate_q ? ONE : floor_gain;
	assign up_d       = (target > gain_q);
	assign diff       = up_d ? (target - gain_q) : (gain_q - target);
	assign env_coef   = (mag_q > env_q) ? attack_q : release_q;
	assign gain_coef  = up_d ? attack_q : release_q;
	assign k          = {1'b1, {COEFF_BITS{1'b0}}} - {1'b0, gain_coef};

	// The envelope blend c*env + (1-c)*mag is formed as mag + c*(env - mag).
	always_comb begin
		priority if (cmd.mul_env) begin
			mul_a = $signed({{(MUL_BITS-COEFF_BITS){1'b0}}, env_coef});
			mul_b = $signed({{(MUL_BITS-SAMPLE_BITS){1'b0}}, env_q})
				- $signed({{(MUL_BITS-SAMPLE_BITS){1'b0}}, mag_q});
		end else if (cmd.mul_gain) begin
			mul_a = $signed({{(MUL_BITS-COEFF_BITS-1){1'b0}}, k});
			mul_b = $signed({{(MUL_BITS-SAMPLE_BITS){1'b0}}, diff});
		end else begin
			mul_a = $signed({{(MUL_BITS-SAMPLE_BITS){1'b0}}, mag_q});
			mul_b = $signed({{(MUL_BITS-SAMPLE_BITS){1'b0}}, gain_q});
		end
	end

	assign mul_p = mul_a * mul_b;

	assign env_sum = $signed({{(PROD_BITS-SAMPLE_BITS-COEFF_BITS){1'b0}}, mag_q,
		{COEFF_BITS{1'b0}}}) + prod_q + RND_C;
	assign env_wide = env_sum[COEFF_BITS+SAMPLE_BITS:COEFF_BITS];
	assign env_d    = (env_wide > {1'b0, ONE}) ? ONE : env_wide[SAMPLE_BITS-1:0];

	assign hold_dec = (hold_q == HOLD_MIN) ? hold_q : (hold_q - (HOLD_BITS+1)'(1));

	assign step_sum  = prod_q + RND_C;
	assign step      = step_sum[COEFF_BITS+SAMPLE_BITS-1:COEFF_BITS];
	assign gain_wide = up_q ? ({1'b0, gain_q} + {1'b0, step})
		: ({1'b0, gain_q} - {1'b0, step});

	always_comb begin
		priority if (gain_wide > {1'b0, ONE}) begin
			gain_d = ONE;
		end else if (gain_wide < {1'b0, floor_gain}) begin
			gain_d = floor_gain;
		end else begin
			gain_d = gain_wide[SAMPLE_BITS-1:0];
		end
	end

	assign out_sum = prod_q + RND_S;
	assign out_mag = out_sum[2*SAMPLE_BITS-2:SAMPLE_BITS-1];

	// Item operands and multiplier result.
	always_ff @(posedge clk) begin
		if (cmd.load_smp) begin
			mag_q <= mag_d;
			neg_q <= raw[SAMPLE_BITS-1];
		end
		if (cmd.mul_gain) begin
			up_q <= up_d;
		end
		if (cmd.mul_env || cmd.mul_gain || cmd.mul_out) begin
			prod_q <= mul_p;
		end
	end

	// Envelope, gate, hold and gain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= '0;
			gain_q <= ONE;
			gate_q <= 1'b1;
			hold_q <= '0;
		end else begin
			if (cmd.upd_gate) begin
				env_q <= env_d;
				priority if (!gate_q && (env_d >= open_thr_q)) begin
					gate_q <= 1'b1;
					hold_q <= $signed({1'b0, hold_smp_q});
				end else if (gate_q && (env_d < close_thr_q)) begin
					hold_q <= hold_dec;
					if (hold_dec[HOLD_BITS] || (hold_dec == '0)) begin
						gate_q <= 1'b0;
					end
				end else if (gate_q) begin
					hold_q <= $signed({1'b0, hold_smp_q});
				end
			end
			if (cmd.upd_gain) begin
				gain_q <= gain_d;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sample_out_q <= $signed(neg_q ? (smp_t'(0) - out_mag) : out_mag);
			gate_out_q   <= gate_q;
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign sample_out    = sample_out_q;
	assign gate_is_open  = gate_out_q;

	a_env_max: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ONE)
		else $error("envelope above unity");

	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= ONE)
		else $error("gain above unity");

	a_hold_floor: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q >= -$signed((HOLD_BITS+1)'(1)))
		else $error("hold count below minus one");

endmodule
`default_nettype wire
